[rtl/spi_mbs_pkg.sv]
// package of types and constants for the spi master byte shifter
package spi_mbs_pkg;

  localparam int unsigned HalfW     = 16;
  localparam int unsigned HalfIdxW  = 5;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 16;

  localparam logic [HalfIdxW-1:0] LastHalf      = 5'd16;
  localparam logic [HalfIdxW-1:0] FirstLateHalf = 5'd2;
  localparam logic [HalfW-1:0]    HalfPeriodRst = 16'd1;
  localparam logic [ModeW-1:0]    SpiModeRst    = 2'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPI_MODE    = 2'd0,
    CFG_HALF_PERIOD = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic             start_req;
    logic [ByteW-1:0] tx_byte;
    logic             miso_level;
  } spi_in_t;

  typedef struct packed {
    logic             sck_level;
    logic             mosi_level;
    logic             busy_res;
    logic             rx_valid;
    logic [ByteW-1:0] rx_byte;
  } spi_res_t;

  typedef struct packed {
    logic [ModeW-1:0] spi_mode;
    logic [HalfW-1:0] half_period;
  } spi_cfg_t;

endpackage

[rtl/spi_master_byte_shifter_top.sv]
// top level of the spi master byte shifter, modes 0 to 3, msb first
//
// Each input transaction on s_axis is one tick of the serial clock
// generator: it carries a start request, the byte to send and the MISO
// level. Each input transaction gives exactly one output transaction on
// m_axis with the SCK and MOSI levels, the busy flag and, in the tick
// that ends a transfer, rx_valid with the received byte.
// The result of a tick sits in the output register in the cycle after it
// is accepted. One tick is taken per clock cycle while m_axis does not
// stall; the combinational step logic and the output register allow this.
// A transfer lasts 17 half periods of half_period ticks each (zero counts as one).
// The cfg port writes spi_mode (index 0) or half_period (index 1); it is
// always ready and should be used only while no transfer runs.
// Reset clears the transfer state, sets mode 0 and a half period of one
// tick. When m_axis stalls the held result stays put and s_axis_tready
// drops, so no tick is taken until the result is accepted.
module spi_master_byte_shifter_top
  import spi_mbs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [0] start_req, [8:1] tx_byte, [9] miso_level, [15:10] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] sck_level, [1] mosi_level, [2] busy_res, [3] rx_valid,
  // [11:4] rx_byte, [15:12] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [HalfW-1:0]    cfg_data_i
);

  spi_cfg_t cfg_q;
  spi_in_t  in_item;
  spi_res_t step_res, out_res;
  logic     accept, free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spi_mode    <= SpiModeRst;
      cfg_q.half_period <= HalfPeriodRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SPI_MODE:    cfg_q.spi_mode    <= cfg_data_i[ModeW-1:0];
        CFG_HALF_PERIOD: cfg_q.half_period <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item.start_req  = s_axis_tdata[0];
  assign in_item.tx_byte    = s_axis_tdata[ByteW:1];
  assign in_item.miso_level = s_axis_tdata[ByteW+1];

  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && free;

  spi_mbs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .in_i   (in_item),
    .cfg_i  (cfg_q),
    .res_o  (step_res)
  );

  spi_mbs_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .res_i   (step_res),
    .free_o  (free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {4'b0000, out_res.rx_byte, out_res.rx_valid, out_res.busy_res,
                         out_res.mosi_level, out_res.sck_level};

endmodule

[rtl/spi_mbs_core.sv]
// transfer state registers and the per-tick step logic
module spi_mbs_core
  import spi_mbs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  spi_in_t  in_i,
  input  spi_cfg_t cfg_i,
  output spi_res_t res_o
);

  logic [HalfIdxW-1:0] half_q, half_d;
  logic [HalfW-1:0]    tick_q, tick_d;
  logic [ByteW-1:0]    tx_q, tx_d;
  logic [ByteW-1:0]    rx_q, rx_d;
  logic                active_q, active_d;
  logic                mosi_q, mosi_d;

  logic                start, act, odd, shifting, last, cpha, idle;
  logic [HalfIdxW-1:0] hi;
  logic [HalfW-1:0]    tc, hp_m1;
  logic [ByteW-1:0]    txs, rxs, rx_new;

  always_comb begin
    cpha  = cfg_i.spi_mode[0];
    idle  = cfg_i.spi_mode[1];
    hp_m1 = (cfg_i.half_period == '0) ? '0 : cfg_i.half_period - HalfW'(1);

    start = !active_q && in_i.start_req;
    act   = active_q || start;
    hi    = start ? '0 : half_q;
    tc    = start ? '0 : tick_q;
    txs   = start ? in_i.tx_byte : tx_q;
    rxs   = start ? '0 : rx_q;

    odd      = hi[0];
    shifting = cpha ? (!odd && (hi >= FirstLateHalf)) : odd;
    last     = (tc >= hp_m1);
    rx_new   = (last && shifting) ? {rxs[ByteW-2:0], in_i.miso_level} : rxs;

    half_d   = half_q;
    tick_d   = tick_q;
    tx_d     = tx_q;
    rx_d     = rx_q;
    active_d = active_q;
    mosi_d   = mosi_q;

    res_o.sck_level = idle;
    res_o.rx_valid  = 1'b0;
    res_o.rx_byte   = '0;

    if (act) begin
      res_o.sck_level = idle ^ odd;
      active_d        = 1'b1;
      half_d          = hi;
      rx_d            = rx_new;
      tx_d            = txs;
      if ((tc == '0) && shifting) begin
        mosi_d = txs[ByteW-1];
        tx_d   = {txs[ByteW-2:0], 1'b0};
      end
      if (last) begin
        tick_d = '0;
        if (hi >= LastHalf) begin
          active_d       = 1'b0;
          half_d         = '0;
          res_o.rx_valid = 1'b1;
          res_o.rx_byte  = rx_new;
        end else begin
          half_d = hi + HalfIdxW'(1);
        end
      end else begin
        tick_d = tc + HalfW'(1);
      end
    end

    res_o.mosi_level = mosi_d;
    res_o.busy_res   = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q   <= '0;
      tick_q   <= '0;
      tx_q     <= '0;
      rx_q     <= '0;
      active_q <= 1'b0;
      mosi_q   <= 1'b0;
    end else if (step_i) begin
      half_q   <= half_d;
      tick_q   <= tick_d;
      tx_q     <= tx_d;
      rx_q     <= rx_d;
      active_q <= active_d;
      mosi_q   <= mosi_d;
    end
  end

  a_half_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q <= LastHalf)
    else $error("half index out of range");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (half_q == '0 && tick_q == '0))
    else $error("counters not cleared while idle");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.rx_valid |-> (!res_o.busy_res && active_q))
    else $error("completion while idle or still busy");

  a_mosi_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(mosi_q))
    else $error("mosi moved without a tick");

endmodule

[rtl/spi_mbs_out_reg.sv]
// result register between the step logic and the output stream
module spi_mbs_out_reg
  import spi_mbs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  spi_res_t res_i,
  output logic     free_o,
  output logic     valid_o,
  input  logic     ready_i,
  output spi_res_t res_o
);

  logic     valid_q, valid_d;
  spi_res_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |-> !load_i)
    else $error("held result overwritten");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |=> (valid_q && $stable(res_q)))
    else $error("stalled result changed");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> valid_q)
    else $error("loaded result not shown");

endmodule

[tb/tb_top.sv]
// self-checking testbench for the spi master byte shifter, one tick per transaction
module tb_top;
  import spi_mbs_pkg::*;

  localparam int DirRows    = 25;
  localparam int NumPhases  = 7;
  localparam int PausePhase = 2;
  localparam int HoldAfter  = 300;
  localparam int LongHold   = 150;
  localparam int Watchdog   = 2000000;

  localparam logic [CfgIdxW-1:0] CfgIdxSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareB = 2'd3;

  localparam spi_res_t IdleRes = '0;
  localparam spi_res_t DoneFF  = '{1'b0, 1'b1, 1'b0, 1'b1, 8'hFF};
  localparam spi_res_t HoldOne = '{1'b0, 1'b1, 1'b0, 1'b0, 8'h00};

  typedef struct packed {
    spi_in_t  tick;
    logic     pinned;
    spi_res_t want;
  } dir_row_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [HalfW-1:0] half;
    logic [11:0]      items;
    logic             starts;
  } phase_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [HalfW-1:0]    cfg_data_i = '0;

  // mode 0, half period 1 after reset; rows with pinned set carry their own result
  dir_row_t dir_rows [DirRows] = '{
    '{'{1'b0, 8'h00, 1'b0}, 1'b1, IdleRes},
    '{'{1'b1, 8'hFF, 1'b1}, 1'b0, IdleRes},
    '{'{1'b1, 8'h00, 1'b1}, 1'b0, IdleRes},
    '{'{1'b0, 8'h00, 1'b1}, 1'b0, IdleRes},
    '{'{1'b1, 8'h00, 1'b1}, 1'b0, IdleRes},
    '{'{1'b0, 8'h00, 1'b1}, 1'b0, IdleRes},
    '{'{1'b1, 8'h00, 1'b1}, 1'b0, IdleRes},
    '{'{1'b0, 8'h00, 1'b1}, 1'b0, IdleRes},
    '{'{1'b1, 8'h00, 1'b1}, 1'b0, IdleRes},
    '{'{1'b0, 8'h00, 1'b1}, 1'b0, IdleRes},
    '{'{1'b1, 8'h00, 1'b1}, 1'b0, IdleRes},
    '{'{1'b0, 8'h00, 1'b1}, 1'b0, IdleRes},
    '{'{1'b1, 8'h00, 1'b1}, 1'b0, IdleRes},
    '{'{1'b0, 8'h00, 1'b1}, 1'b0, IdleRes},
    '{'{1'b1, 8'h00, 1'b1}, 1'b0, IdleRes},
    '{'{1'b0, 8'h00, 1'b1}, 1'b0, IdleRes},
    '{'{1'b1, 8'h00, 1'b1}, 1'b0, IdleRes},
    // completing tick, start ignored
    '{'{1'b1, 8'h5A, 1'b1}, 1'b1, DoneFF},
    // mosi holds the last bit
    '{'{1'b0, 8'h00, 1'b0}, 1'b1, HoldOne},
    '{'{1'b1, 8'h00, 1'b0}, 1'b0, IdleRes},
    '{'{1'b0, 8'hFF, 1'b0}, 1'b0, IdleRes},
    '{'{1'b0, 8'hFF, 1'b0}, 1'b0, IdleRes},
    '{'{1'b0, 8'hFF, 1'b0}, 1'b0, IdleRes},
    '{'{1'b0, 8'hFF, 1'b0}, 1'b0, IdleRes},
    '{'{1'b0, 8'hFF, 1'b0}, 1'b0, IdleRes}
  };

  // zero half period behaves as one tick; 65535 only sees idle ticks
  phase_t plan [NumPhases] = '{
    '{2'd1, 16'd0,     12'd200, 1'b1},
    '{2'd2, 16'd1,     12'd200, 1'b1},
    '{2'd3, 16'd2,     12'd250, 1'b1},
    '{2'd0, 16'd3,     12'd250, 1'b1},
    '{2'd3, 16'd65535, 12'd40,  1'b0},
    '{2'd1, 16'd12,    12'd250, 1'b1},
    '{2'd2, 16'd1,     12'd200, 1'b1}
  };

  // shifter state as predicted
  logic [ModeW-1:0]    cur_mode = SpiModeRst;
  logic [HalfW-1:0]    cur_half_ticks = HalfPeriodRst;
  logic [HalfIdxW-1:0] xfer_half = '0;
  logic [HalfW-1:0]    xfer_tick = '0;
  logic [ByteW-1:0]    out_shift = '0;
  logic [ByteW-1:0]    in_shift = '0;
  logic                xfer_on = 1'b0;
  logic                mosi_q = 1'b0;

  spi_res_t pin_levels_due [$];
  int       ticks_sent = 0;
  int       bytes_done = 0;
  int       results_seen = 0;
  int       fail_count = 0;
  int       burst_left = 0;

  spi_master_byte_shifter_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic spi_res_t shifter_tick(input spi_in_t t);
    spi_res_t         r;
    logic             cpha;
    logic             cpol;
    logic             odd;
    logic             shifting;
    logic             last_tick;
    logic [HalfW-1:0] hp;
    cpha = cur_mode[0];
    cpol = cur_mode[1];
    hp = (cur_half_ticks == '0) ? 16'd1 : cur_half_ticks;
    r = '0;
    r.sck_level = cpol;
    if (!xfer_on && t.start_req) begin
      xfer_on = 1'b1;
      out_shift = t.tx_byte;
      in_shift = '0;
      xfer_half = '0;
      xfer_tick = '0;
    end
    if (xfer_on) begin
      odd = xfer_half[0];
      shifting = cpha ? (!odd && xfer_half >= FirstLateHalf) : odd;
      last_tick = (xfer_tick >= hp - 16'd1);
      r.sck_level = odd ? ~cpol : cpol;
      if (xfer_tick == '0 && shifting) begin
        mosi_q = out_shift[ByteW-1];
        out_shift = {out_shift[ByteW-2:0], 1'b0};
      end
      if (last_tick && shifting) begin
        in_shift = {in_shift[ByteW-2:0], t.miso_level};
      end
      if (last_tick) begin
        xfer_tick = '0;
        if (xfer_half >= LastHalf) begin
          xfer_on = 1'b0;
          xfer_half = '0;
          r.rx_valid = 1'b1;
          r.rx_byte = in_shift;
        end else begin
          xfer_half = xfer_half + 5'd1;
        end
      end else begin
        xfer_tick = xfer_tick + 16'd1;
      end
    end
    r.mosi_level = mosi_q;
    r.busy_res = xfer_on;
    return r;
  endfunction

  function automatic logic [InDataW-1:0] pack_tick(input spi_in_t t);
    return {6'b0, t.miso_level, t.tx_byte, t.start_req};
  endfunction

  function automatic spi_res_t unpack_levels(input logic [OutDataW-1:0] d);
    spi_res_t r;
    r.sck_level = d[0];
    r.mosi_level = d[1];
    r.busy_res = d[2];
    r.rx_valid = d[3];
    r.rx_byte = d[11:4];
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s expected %0h got %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 1);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_tick(input spi_in_t t, input logic pinned, input spi_res_t pinned_res);
    spi_res_t due;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pack_tick(t);
    do @(posedge clk_i); while (!s_axis_tready);
    due = shifter_tick(t);
    pin_levels_due.push_back(pinned ? pinned_res : due);
    ticks_sent++;
  endtask

  task automatic flush_results();
    s_axis_tvalid <= 1'b0;
    while (pin_levels_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [HalfW-1:0] word);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= word;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SPI_MODE: cur_mode = word[ModeW-1:0];
      CFG_HALF_PERIOD: cur_half_ticks = word;
      default: ;
    endcase
  endtask

  task automatic retune(input logic [ModeW-1:0] mode, input logic [HalfW-1:0] hp);
    spi_in_t          t;
    logic [HalfW-1:0] word;
    // let the running transfer finish before touching the registers
    while (xfer_on) begin
      t.start_req = 1'b0;
      t.tx_byte = 8'($urandom);
      t.miso_level = 1'($urandom);
      pace_sender();
      send_tick(t, 1'b0, '0);
    end
    flush_results();
    word = 16'($urandom);
    word[ModeW-1:0] = mode;
    write_reg(CFG_SPI_MODE, word);
    write_reg(CFG_HALF_PERIOD, hp);
    write_reg(CfgIdxSpareA, 16'hFFFF);
    write_reg(CfgIdxSpareB, 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : level_check
    spi_res_t got;
    spi_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = unpack_levels(m_axis_tdata);
      results_seen++;
      if (got.rx_valid) bytes_done++;
      if (pin_levels_due.size() == 0) begin
        $error("unexpected result transaction %0h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pin_levels_due.pop_front();
        check_field("sck_level", 32'(want.sck_level), 32'(got.sck_level));
        check_field("mosi_level", 32'(want.mosi_level), 32'(got.mosi_level));
        check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
        check_field("rx_valid", 32'(want.rx_valid), 32'(got.rx_valid));
        check_field("rx_byte", 32'(want.rx_byte), 32'(got.rx_byte));
        check_field("pad", 0, 32'(m_axis_tdata[15:12]));
      end
    end
  end

  initial begin : sink
    int   style;
    int   style_left;
    int   pattern_cnt;
    logic held_long;
    style = 0;
    style_left = 0;
    pattern_cnt = 0;
    held_long = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held_long && results_seen >= HoldAfter) begin
        held_long = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      if (style_left == 0) begin
        style = $urandom_range(2);
        style_left = $urandom_range(64, 8);
      end
      style_left--;
      case (style)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(1));
        default: m_axis_tready <= (pattern_cnt % 3 != 0);
      endcase
      pattern_cnt++;
      @(posedge clk_i);
    end
  end

  initial begin : watchdog
    #(Watchdog);
    $display("spi_master_byte_shifter_top verification failed");
    $finish;
  end

  initial begin : stimulus
    spi_in_t t;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < DirRows; i++) begin
      pace_sender();
      send_tick(dir_rows[i].tick, dir_rows[i].pinned, dir_rows[i].want);
    end
    for (int p = 0; p < NumPhases; p++) begin
      retune(plan[p].mode, plan[p].half);
      for (int n = 0; n < int'(plan[p].items); n++) begin
        if (p == PausePhase && n == int'(plan[p].items) / 2) flush_results();
        t.start_req = plan[p].starts ? 1'($urandom_range(1)) : 1'b0;
        t.tx_byte = 8'($urandom);
        t.miso_level = 1'($urandom);
        pace_sender();
        send_tick(t, 1'b0, '0);
      end
    end
    flush_results();
    repeat (4) @(posedge clk_i);
    $display("%0d ticks over clock modes 0 to 3, half periods 0, 1, 2, 3, 12 and 65535",
             ticks_sent);
    $display("%0d bytes exchanged, with one long output stall and one full drain mid run",
             bytes_done);
    if (fail_count == 0) begin
      $display("spi_master_byte_shifter_top verification clean");
    end else begin
      $display("spi_master_byte_shifter_top verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/spi_mbs_pkg.sv
rtl/spi_mbs_core.sv
rtl/spi_mbs_out_reg.sv
rtl/spi_master_byte_shifter_top.sv
tb/tb_top.sv
